// File: src/nbg_pkg.sv
// Shared types and constants for the 2D gravity N-body block.
// Used by nbg_serial, nbody_gravity_euler_2d_top and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nbg_pkg;
   localparam int unsigned DEF_MAX_BODIES = 64;
   localparam int unsigned DEF_FRAC_BITS  = 16;
   localparam int unsigned SER_W          = 64;

   typedef struct packed {
      logic start;
      logic root;
   } ser_ctl_type;
endpackage
`default_nettype wire

// File: src/nbg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nbg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: src/nbg_serial.sv
// Bit-serial unit: integer square root or unsigned division, one bit per cycle.
// Depends on nbg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbg_serial import nbg_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ser_ctl_type      ctl,
   input  wire logic [SER_W-1:0] opd_a,
   input  wire logic [SER_W-1:0] opd_b,
   output logic                  done,
   output logic [SER_W-1:0]      result
);
   localparam int unsigned CNT_W = $clog2(SER_W);

   logic             run_ff;
   logic             done_ff;
   logic             root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SER_W-1:0] acc_ff;
   logic [SER_W-1:0] res_ff;
   logic [SER_W-1:0] bit_ff;
   logic [SER_W-1:0] den_ff;

   logic [SER_W-1:0] sum_in;
   logic [SER_W:0]   trial_in;
   logic             ge_root;
   logic             ge_div;

   always_comb begin
      sum_in   = res_ff + bit_ff;
      trial_in = {acc_ff, res_ff[SER_W-1]};
      ge_root  = acc_ff >= sum_in;
      ge_div   = trial_in >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            run_ff  <= 1'b1;
            root_ff <= ctl.root;
            if (ctl.root) begin
               acc_ff <= opd_a;
               res_ff <= '0;
               bit_ff <= SER_W'(1) << (SER_W - 2);
               cnt_ff <= CNT_W'(SER_W / 2 - 1);
            end else begin
               acc_ff <= '0;
               res_ff <= opd_a;
               den_ff <= opd_b;
               cnt_ff <= CNT_W'(SER_W - 1);
            end
         end else if (run_ff) begin
            if (root_ff) begin
               if (ge_root) begin
                  acc_ff <= acc_ff - sum_in;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end else begin
               if (ge_div) begin
                  acc_ff <= SER_W'(trial_in - {1'b0, den_ff});
                  res_ff <= {res_ff[SER_W-2:0], 1'b1};
               end else begin
                  acc_ff <= trial_in[SER_W-1:0];
                  res_ff <= {res_ff[SER_W-2:0], 1'b0};
               end
            end
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

// File: src/nbody_gravity_euler_2d_top.sv
// Top level of the 2D direct-sum gravity N-body block with Euler steps.
// Depends on nbg_pkg, nbg_ram and nbg_serial.
//
// Channel   Ports                                   Handshake
// request   req_mass, req_pos_*, req_vel_*, last    req_start high, busy low
// response  rsp_body_index .. rsp_overflow          rsp_valid, one cycle each
// config    csr_index, csr_wdata                    csr_we, no wait
//
// Loading takes one transaction per cycle while busy is low. A transaction marked
// last starts the run. Each step works through every ordered body pair with the
// serial root and the serial divider, then updates every body. Readout reports
// each body in turn. Synchronous reset restores the control and CSR registers.
// The receiver cannot stall; busy stays high from the last body to the last result.
`timescale 1ns / 1ps
`default_nettype none
module nbody_gravity_euler_2d_top import nbg_pkg::*; #(
   parameter int unsigned MAX_BODIES = DEF_MAX_BODIES,
   parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   output logic             busy,
   input  wire logic [30:0] req_mass,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_vel_x,
   input  wire logic [31:0] req_vel_y,
   input  wire logic        req_last_body,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [30:0] csr_wdata,
   output logic             rsp_valid,
   output logic [5:0]       rsp_body_index,
   output logic [31:0]      rsp_out_pos_x,
   output logic [31:0]      rsp_out_pos_y,
   output logic [31:0]      rsp_out_vel_x,
   output logic [31:0]      rsp_out_vel_y,
   output logic             rsp_last_result,
   output logic             rsp_overflow
);
   localparam int unsigned AW     = $clog2(MAX_BODIES);
   localparam int unsigned CW     = $clog2(MAX_BODIES + 1);
   localparam int unsigned ACC_W  = 33 + AW;
   localparam int unsigned DT_Q   = ((5 << FRAC_BITS) + 50) / 100;
   localparam int unsigned EPS_R  = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam int unsigned EPS_Q  = (EPS_R == 0) ? 1 : EPS_R;

   localparam logic       REG_GRAV = 1'b0;
   localparam logic       REG_STEP = 1'b1;

   localparam logic [5:0] ST_IDLE = 6'd0;
   localparam logic [5:0] ST_SBEG = 6'd1;
   localparam logic [5:0] ST_IRD  = 6'd2;
   localparam logic [5:0] ST_ILD  = 6'd3;
   localparam logic [5:0] ST_PRD  = 6'd4;
   localparam logic [5:0] ST_PDX  = 6'd5;
   localparam logic [5:0] ST_SQX  = 6'd6;
   localparam logic [5:0] ST_SQY  = 6'd7;
   localparam logic [5:0] ST_SQA  = 6'd8;
   localparam logic [5:0] ST_SQS  = 6'd9;
   localparam logic [5:0] ST_SQW  = 6'd10;
   localparam logic [5:0] ST_CUB0 = 6'd11;
   localparam logic [5:0] ST_CUB1 = 6'd12;
   localparam logic [5:0] ST_CUB2 = 6'd13;
   localparam logic [5:0] ST_DCAP = 6'd14;
   localparam logic [5:0] ST_DVS  = 6'd15;
   localparam logic [5:0] ST_DVW  = 6'd16;
   localparam logic [5:0] ST_TX0  = 6'd17;
   localparam logic [5:0] ST_TX1  = 6'd18;
   localparam logic [5:0] ST_TX2  = 6'd19;
   localparam logic [5:0] ST_TY0  = 6'd20;
   localparam logic [5:0] ST_TY1  = 6'd21;
   localparam logic [5:0] ST_TY2  = 6'd22;
   localparam logic [5:0] ST_WACC = 6'd23;
   localparam logic [5:0] ST_URD  = 6'd24;
   localparam logic [5:0] ST_UM0  = 6'd25;
   localparam logic [5:0] ST_UM1  = 6'd26;
   localparam logic [5:0] ST_UM2  = 6'd27;
   localparam logic [5:0] ST_UM3  = 6'd28;
   localparam logic [5:0] ST_UM4  = 6'd29;
   localparam logic [5:0] ST_UW   = 6'd30;
   localparam logic [5:0] ST_ORD  = 6'd31;
   localparam logic [5:0] ST_OEM  = 6'd32;

   function automatic logic signed [ACC_W-1:0] pair_term(input logic [95:0] p,
                                                         input logic neg);
      logic [95:0]      m;
      logic [ACC_W-1:0] t;
      m = p >> FRAC_BITS;
      t = (m > 96'h8000_0000) ? ACC_W'(33'h0_8000_0000) : ACC_W'(m[31:0]);
      pair_term = neg ? -t : t;
   endfunction

   function automatic logic [31:0] sat_acc(input logic [ACC_W-1:0] v);
      if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
         sat_acc = v[31:0];
      end else begin
         sat_acc = v[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
   endfunction

   function automatic logic [32:0] scale_dt(input logic [63:0] p, input logic neg);
      logic [63:0] m;
      m = p >> FRAC_BITS;
      scale_dt = neg ? -{1'b0, m[31:0]} : {1'b0, m[31:0]};
   endfunction

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [32:0] b);
      logic [33:0] s;
      s = {{2{a[31]}}, a} + {b[32], b};
      if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
         add_sat = s[31:0];
      end else begin
         add_sat = s[33] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] v);
      abs32 = v[31] ? -v : v;
   endfunction

   logic [5:0]       state_ff;
   logic [5:0]       state_in;
   logic [CW-1:0]    count_ff;
   logic             dropped_ff;
   logic [30:0]      grav_ff;
   logic [15:0]      steps_ff;
   logic [15:0]      step_ff;
   logic [AW-1:0]    i_ff;
   logic [AW-1:0]    j_ff;
   logic [31:0]      pix_ff;
   logic [31:0]      piy_ff;
   logic [31:0]      ux_ff;
   logic [31:0]      uy_ff;
   logic             xneg_ff;
   logic             yneg_ff;
   logic [63:0]      s_ff;
   logic [31:0]      r_ff;
   logic [95:0]      p_ff;
   logic [63:0]      d_ff;
   logic [63:0]      coef_ff;
   logic [ACC_W-1:0] ax_ff;
   logic [ACC_W-1:0] ay_ff;
   logic [63:0]      prod_ff;
   logic [32:0]      sc_ff;
   logic [31:0]      npx_ff;
   logic [31:0]      npy_ff;
   logic [31:0]      nvx_ff;

   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic             accept;
   logic             store;
   logic [AW-1:0]    nlast;
   logic [32:0]      dx;
   logic [32:0]      dy;
   logic [32:0]      adx;
   logic [32:0]      ady;
   logic [64:0]      ssum;
   logic [95:0]      cube;
   logic [63:0]      dcap;

   logic [63:0]      pos_rd;
   logic [63:0]      vel_rd;
   logic [63:0]      acc_rd;
   logic [30:0]      mass_rd;
   logic             pos_we;
   logic [AW-1:0]    wr_addr;
   logic [63:0]      pos_wdata;
   logic [63:0]      vel_wdata;
   logic [AW-1:0]    pos_raddr;

   ser_ctl_type      ser_ctl;
   logic [63:0]      ser_a;
   logic             ser_done;
   logic [63:0]      ser_res;

   assign busy   = state_ff != ST_IDLE;
   assign accept = req_start && !busy;
   assign store  = accept && (count_ff < CW'(MAX_BODIES));
   assign nlast  = AW'(count_ff - 1'b1);

   always_comb begin
      dx   = {pos_rd[31], pos_rd[31:0]} - {pix_ff[31], pix_ff};
      dy   = {pos_rd[63], pos_rd[63:32]} - {piy_ff[31], piy_ff};
      adx  = dx[32] ? -dx : dx;
      ady  = dy[32] ? -dy : dy;
      ssum = {1'b0, s_ff} + {1'b0, prod_ff};
      cube = p_ff >> (2 * FRAC_BITS);
      dcap = (|cube[95:64]) ? '1 : cube[63:0];
      if (dcap < 64'(EPS_Q)) begin
         dcap = 64'(EPS_Q);
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX:  begin mul_a = ux_ff;            mul_b = ux_ff;            end
         ST_SQY:  begin mul_a = uy_ff;            mul_b = uy_ff;            end
         ST_CUB0: begin mul_a = r_ff;             mul_b = s_ff[31:0];       end
         ST_CUB1: begin mul_a = r_ff;             mul_b = s_ff[63:32];      end
         ST_DCAP: begin mul_a = {1'b0, grav_ff};  mul_b = {1'b0, mass_rd};  end
         ST_TX0:  begin mul_a = coef_ff[31:0];    mul_b = ux_ff;            end
         ST_TX1:  begin mul_a = coef_ff[63:32];   mul_b = ux_ff;            end
         ST_TX2:  begin mul_a = coef_ff[31:0];    mul_b = uy_ff;            end
         ST_TY0:  begin mul_a = coef_ff[63:32];   mul_b = uy_ff;            end
         ST_UM0:  begin mul_a = abs32(vel_rd[31:0]);  mul_b = 32'(DT_Q);    end
         ST_UM1:  begin mul_a = abs32(vel_rd[63:32]); mul_b = 32'(DT_Q);    end
         ST_UM2:  begin mul_a = abs32(acc_rd[31:0]);  mul_b = 32'(DT_Q);    end
         ST_UM3:  begin mul_a = abs32(acc_rd[63:32]); mul_b = 32'(DT_Q);    end
         default: begin mul_a = '0;               mul_b = '0;               end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_last_body) state_in = ST_SBEG;
         ST_SBEG: state_in = (step_ff == steps_ff) ? ST_ORD : ST_IRD;
         ST_IRD:  state_in = ST_ILD;
         ST_ILD:  state_in = ST_PRD;
         ST_PRD: begin
            if (j_ff != i_ff) begin
               state_in = ST_PDX;
            end else if (j_ff == nlast) begin
               state_in = ST_WACC;
            end
         end
         ST_PDX:  state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SQA;
         ST_SQA:  state_in = ST_SQS;
         ST_SQS:  state_in = ST_SQW;
         ST_SQW:  if (ser_done) state_in = ST_CUB0;
         ST_CUB0: state_in = ST_CUB1;
         ST_CUB1: state_in = ST_CUB2;
         ST_CUB2: state_in = ST_DCAP;
         ST_DCAP: state_in = ST_DVS;
         ST_DVS:  state_in = ST_DVW;
         ST_DVW:  if (ser_done) state_in = ST_TX0;
         ST_TX0:  state_in = ST_TX1;
         ST_TX1:  state_in = ST_TX2;
         ST_TX2:  state_in = ST_TY0;
         ST_TY0:  state_in = ST_TY1;
         ST_TY1:  state_in = ST_TY2;
         ST_TY2:  state_in = (j_ff == nlast) ? ST_WACC : ST_PRD;
         ST_WACC: state_in = (i_ff == nlast) ? ST_URD : ST_IRD;
         ST_URD:  state_in = ST_UM0;
         ST_UM0:  state_in = ST_UM1;
         ST_UM1:  state_in = ST_UM2;
         ST_UM2:  state_in = ST_UM3;
         ST_UM3:  state_in = ST_UM4;
         ST_UM4:  state_in = ST_UW;
         ST_UW:   state_in = (i_ff == nlast) ? ST_SBEG : ST_URD;
         ST_ORD:  state_in = ST_OEM;
         ST_OEM:  state_in = (i_ff == nlast) ? ST_IDLE : ST_ORD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         grav_ff    <= 31'd65536;
         steps_ff   <= 16'd1;
         step_ff    <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_GRAV: grav_ff  <= csr_wdata;
               REG_STEP: steps_ff <= csr_wdata[15:0];
               default:  grav_ff  <= grav_ff;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (store) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     dropped_ff <= 1'b1;
                  end
               end
               step_ff <= '0;
            end
            ST_SBEG: i_ff <= '0;
            ST_ILD: begin
               pix_ff <= pos_rd[31:0];
               piy_ff <= pos_rd[63:32];
               j_ff   <= '0;
               ax_ff  <= '0;
               ay_ff  <= '0;
            end
            ST_PRD: if (j_ff == i_ff && j_ff != nlast) j_ff <= j_ff + 1'b1;
            ST_PDX: begin
               ux_ff   <= adx[31:0];
               uy_ff   <= ady[31:0];
               xneg_ff <= dx[32];
               yneg_ff <= dy[32];
            end
            ST_SQY:  s_ff <= prod_ff;
            ST_SQA:  s_ff <= ssum[64] ? '1 : ssum[63:0];
            ST_SQW:  r_ff <= ser_res[31:0];
            ST_CUB1: p_ff <= 96'(prod_ff);
            ST_CUB2: p_ff <= p_ff + {prod_ff, 32'h0};
            ST_DCAP: d_ff <= dcap;
            ST_DVW:  coef_ff <= ser_res;
            ST_TX1:  p_ff <= 96'(prod_ff);
            ST_TX2:  p_ff <= p_ff + {prod_ff, 32'h0};
            ST_TY0: begin
               ax_ff <= ax_ff + pair_term(p_ff, xneg_ff);
               p_ff  <= 96'(prod_ff);
            end
            ST_TY1:  p_ff <= p_ff + {prod_ff, 32'h0};
            ST_TY2: begin
               ay_ff <= ay_ff + pair_term(p_ff, yneg_ff);
               if (j_ff != nlast) j_ff <= j_ff + 1'b1;
            end
            ST_WACC: i_ff <= (i_ff == nlast) ? '0 : i_ff + 1'b1;
            ST_UM1:  sc_ff <= scale_dt(prod_ff, vel_rd[31]);
            ST_UM2: begin
               npx_ff <= add_sat(pos_rd[31:0], sc_ff);
               sc_ff  <= scale_dt(prod_ff, vel_rd[63]);
            end
            ST_UM3: begin
               npy_ff <= add_sat(pos_rd[63:32], sc_ff);
               sc_ff  <= scale_dt(prod_ff, acc_rd[31]);
            end
            ST_UM4: begin
               nvx_ff <= add_sat(vel_rd[31:0], sc_ff);
               sc_ff  <= scale_dt(prod_ff, acc_rd[63]);
            end
            ST_UW: begin
               if (i_ff == nlast) begin
                  i_ff    <= '0;
                  step_ff <= step_ff + 1'b1;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_OEM: begin
               if (i_ff == nlast) begin
                  count_ff   <= '0;
                  dropped_ff <= 1'b0;
                  i_ff       <= '0;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            default: step_ff <= step_ff;
         endcase
      end
   end

   always_comb begin
      pos_we    = store || state_ff == ST_UW;
      wr_addr   = (state_ff == ST_IDLE) ? count_ff[AW-1:0] : i_ff;
      pos_wdata = (state_ff == ST_IDLE) ? {req_pos_y, req_pos_x} : {npy_ff, npx_ff};
      vel_wdata = (state_ff == ST_IDLE) ? {req_vel_y, req_vel_x}
                                        : {add_sat(vel_rd[63:32], sc_ff), nvx_ff};
      pos_raddr = (state_ff == ST_PRD) ? j_ff : i_ff;
      ser_ctl.start = state_ff == ST_SQS || state_ff == ST_DVS;
      ser_ctl.root  = state_ff == ST_SQS;
      ser_a         = (state_ff == ST_SQS) ? s_ff : prod_ff;
   end

   nbg_ram #(.WIDTH(31), .DEPTH(MAX_BODIES)) u_mass_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (wr_addr),
      .wr_data (req_mass),
      .rd_addr (j_ff),
      .rd_data (mass_rd)
   );

   nbg_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (wr_addr),
      .wr_data (pos_wdata),
      .rd_addr (pos_raddr),
      .rd_data (pos_rd)
   );

   nbg_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_vel_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (wr_addr),
      .wr_data (vel_wdata),
      .rd_addr (i_ff),
      .rd_data (vel_rd)
   );

   nbg_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_WACC),
      .wr_addr (i_ff),
      .wr_data ({sat_acc(ay_ff), sat_acc(ax_ff)}),
      .rd_addr (i_ff),
      .rd_data (acc_rd)
   );

   nbg_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ser_ctl),
      .opd_a  (ser_a),
      .opd_b  (d_ff),
      .done   (ser_done),
      .result (ser_res)
   );

   assign rsp_valid       = state_ff == ST_OEM;
   assign rsp_body_index  = 6'(i_ff);
   assign rsp_out_pos_x   = pos_rd[31:0];
   assign rsp_out_pos_y   = pos_rd[63:32];
   assign rsp_out_vel_x   = vel_rd[31:0];
   assign rsp_out_vel_y   = vel_rd[63:32];
   assign rsp_last_result = i_ff == nlast;
   assign rsp_overflow    = dropped_ff;

`ifndef SYNTHESIS
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("Result strobe outside a run.");
   a_ser_wait: assert property (@(posedge clock) disable iff (reset)
      ser_done |-> (state_ff == ST_SQW || state_ff == ST_DVW))
      else $error("Serial unit finished while nobody waited.");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> !busy)
      else $error("Block stayed busy after the final result.");
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_body) |=> (busy && count_ff != '0))
      else $error("Final body did not start a run.");
`endif
endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for nbody_gravity_euler_2d_top: it loads body sets,
// predicts every Euler run in a scoreboard class and checks each reported body.
// Depends on nbg_pkg and the RTL under src; reads no files.
`timescale 1ns / 1ps
module tb;
   import nbg_pkg::*;

   localparam bit  REG_GRAV   = 1'b0;
   localparam bit  REG_STEPS  = 1'b1;
   localparam int  BODY_CAP   = DEF_MAX_BODIES;
   localparam longint unsigned DT_Q  = 3277;
   localparam longint unsigned EPS_Q = 7;
   localparam longint unsigned CYCLE_LIMIT = 20_000_000;

   typedef struct {
      bit [5:0]  idx;
      bit [31:0] px, py, vx, vy;
      bit        last, ovf;
   } body_report_type;

   class nbody_tracker;
      bit [30:0] grav;
      bit [15:0] steps;
      bit [30:0] mass_q[BODY_CAP];
      int        pos_x[BODY_CAP], pos_y[BODY_CAP], vel_x[BODY_CAP], vel_y[BODY_CAP];
      int        acc_x[BODY_CAP], acc_y[BODY_CAP];
      int        held;
      bit        dropped;
      body_report_type expected_bodies[$];
      int        mismatches, bodies_checked, runs, overflow_runs;

      function new();
         grav = 31'd65536;
         steps = 16'd1;
         held = 0;
         dropped = 0;
      endfunction

      function int sat32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return int'(v);
      endfunction

      function longint unsigned mul_shift(longint unsigned a, longint unsigned b, int sh,
                                          longint unsigned cap);
         logic [127:0] p;
         logic [127:0] r;
         p = {64'd0, a} * {64'd0, b};
         r = p >> sh;
         return (r > {64'd0, cap}) ? cap : r[63:0];
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint scale_dt(int v);
         longint unsigned mag;
         mag = (v < 0) ? longint'(-longint'(v)) : longint'(v);
         mag = (mag * DT_Q) >> 16;
         return (v < 0) ? -longint'(mag) : longint'(mag);
      endfunction

      function longint pull_term(longint delta, longint unsigned coef);
         longint unsigned mag, t;
         mag = (delta < 0) ? longint'(-delta) : longint'(delta);
         t = mul_shift(coef, mag, 16, 64'h80000000);
         return (delta < 0) ? -longint'(t) : longint'(t);
      endfunction

      function void euler_step(int n);
         longint ax, ay, dx, dy;
         longint unsigned ux, uy, s, s2, r, d, coef;
         for (int i = 0; i < n; i++) begin
            ax = 0;
            ay = 0;
            for (int j = 0; j < n; j++) begin
               if (i == j) continue;
               dx = longint'(pos_x[j]) - longint'(pos_x[i]);
               dy = longint'(pos_y[j]) - longint'(pos_y[i]);
               ux = (dx < 0) ? -dx : dx;
               uy = (dy < 0) ? -dy : dy;
               s = ux * ux;
               s2 = uy * uy;
               s = (s > 64'hFFFFFFFFFFFFFFFF - s2) ? 64'hFFFFFFFFFFFFFFFF : s + s2;
               r = int_sqrt(s);
               d = mul_shift(r, s, 32, 64'hFFFFFFFFFFFFFFFF);
               if (d < EPS_Q) d = EPS_Q;
               coef = ({33'd0, grav} * {33'd0, mass_q[j]}) / d;
               ax += pull_term(dx, coef);
               ay += pull_term(dy, coef);
            end
            acc_x[i] = sat32(ax);
            acc_y[i] = sat32(ay);
         end
         for (int i = 0; i < n; i++) begin
            pos_x[i] = sat32(longint'(pos_x[i]) + scale_dt(vel_x[i]));
            pos_y[i] = sat32(longint'(pos_y[i]) + scale_dt(vel_y[i]));
         end
         for (int i = 0; i < n; i++) begin
            vel_x[i] = sat32(longint'(vel_x[i]) + scale_dt(acc_x[i]));
            vel_y[i] = sat32(longint'(vel_y[i]) + scale_dt(acc_y[i]));
         end
      endfunction

      function void note_body(bit [30:0] m, bit [31:0] px, bit [31:0] py, bit [31:0] vx,
                              bit [31:0] vy, bit last);
         body_report_type rep;
         if (held < BODY_CAP) begin
            mass_q[held] = m;
            pos_x[held] = px;
            pos_y[held] = py;
            vel_x[held] = vx;
            vel_y[held] = vy;
            held++;
         end else begin
            dropped = 1;
         end
         if (!last) return;
         for (int s = 0; s < steps; s++) euler_step(held);
         for (int k = 0; k < held; k++) begin
            rep.idx = k[5:0];
            rep.px = pos_x[k];
            rep.py = pos_y[k];
            rep.vx = vel_x[k];
            rep.vy = vel_y[k];
            rep.last = (k + 1 == held);
            rep.ovf = dropped;
            expected_bodies.push_back(rep);
         end
         runs++;
         if (dropped) overflow_runs++;
         held = 0;
         dropped = 0;
      endfunction

      function void check_body(body_report_type got);
         body_report_type exp;
         if (expected_bodies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result for body %0d", got.idx);
            return;
         end
         exp = expected_bodies.pop_front();
         bodies_checked++;
         if (got.idx != exp.idx || got.px != exp.px || got.py != exp.py ||
             got.vx != exp.vx || got.vy != exp.vy || got.last != exp.last ||
             got.ovf != exp.ovf) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: body mismatch, expected idx %0d pos %h %h vel %h %h last %b ovf %b",
                        exp.idx, exp.px, exp.py, exp.vx, exp.vy, exp.last, exp.ovf);
               $display("       actual            idx %0d pos %h %h vel %h %h last %b ovf %b",
                        got.idx, got.px, got.py, got.vx, got.vy, got.last, got.ovf);
            end
         end
      endfunction

      function int pending();
         return expected_bodies.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_start;
   logic        busy;
   logic [30:0] req_mass;
   logic [31:0] req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic        req_last_body;
   logic        csr_we;
   logic        csr_index;
   logic [30:0] csr_wdata;
   logic        rsp_valid;
   logic [5:0]  rsp_body_index;
   logic [31:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_vel_x, rsp_out_vel_y;
   logic        rsp_last_result;
   logic        rsp_overflow;

   nbody_tracker tracker;
   longint unsigned cycles;
   int  burst_left;
   bit  steady;
   int  bodies_sent;

   nbody_gravity_euler_2d_top u_dut (
      .clock(clock), .reset(reset), .req_start(req_start), .busy(busy),
      .req_mass(req_mass), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_last_body(req_last_body),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_body_index(rsp_body_index),
      .rsp_out_pos_x(rsp_out_pos_x), .rsp_out_pos_y(rsp_out_pos_y),
      .rsp_out_vel_x(rsp_out_vel_x), .rsp_out_vel_y(rsp_out_vel_y),
      .rsp_last_result(rsp_last_result), .rsp_overflow(rsp_overflow)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      body_report_type got;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
      if (!reset && rsp_valid) begin
         got.idx = rsp_body_index;
         got.px = rsp_out_pos_x;
         got.py = rsp_out_pos_y;
         got.vx = rsp_out_vel_x;
         got.vy = rsp_out_vel_y;
         got.last = rsp_last_result;
         got.ovf = rsp_overflow;
         tracker.check_body(got);
      end
   end

   task automatic send_body(bit [30:0] m, bit [31:0] px, bit [31:0] py, bit [31:0] vx,
                            bit [31:0] vy, bit last);
      req_start <= 1'b1;
      req_mass <= m;
      req_pos_x <= px;
      req_pos_y <= py;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_last_body <= last;
      do @(posedge clock); while (busy);
      tracker.note_body(m, px, py, vx, vy, last);
      bodies_sent++;
      if (!steady) begin
         if (burst_left == 0) begin
            req_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(0, 8);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_idle();
      req_start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() > 0 || busy) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(bit idx, bit [30:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_GRAV) tracker.grav = value;
      else tracker.steps = value[15:0];
   endtask

   function automatic bit [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         3: return 32'd0;
         default: return 32'($urandom_range(0, 32'h100000)) - 32'h80000;
      endcase
   endfunction

   function automatic bit [30:0] rand_mass();
      case ($urandom_range(0, 5))
         0: return 31'($urandom());
         1: return 31'd0;
         2: return 31'h7FFFFFFF;
         default: return 31'($urandom_range(1, 32'h40000));
      endcase
   endfunction

   function automatic bit [30:0] rand_grav();
      case ($urandom_range(0, 4))
         0: return 31'd65536;
         1: return 31'($urandom());
         2: return 31'h7FFFFFFF;
         3: return 31'd0;
         default: return 31'($urandom_range(1, 32'h20000));
      endcase
   endfunction

   initial begin
      int n;
      bit [31:0] cx, cy;
      tracker = new();
      cycles = 0;
      burst_left = 0;
      steady = 0;
      bodies_sent = 0;
      reset = 1'b1;
      req_start = 1'b0;
      req_mass = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_last_body = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_GRAV;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset settings: extreme fields plus a coincident pair.
      send_body(31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
      send_body(31'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
      send_body(31'd65536, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0, 1);
      // Very close heavy pair, and a lone body.
      send_body(31'h7FFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 0);
      send_body(31'h7FFFFFFF, 32'd1, 32'd1, 32'd0, 32'd0, 1);
      send_body(31'd65536, 32'd65536, 32'hFFFF0000, 32'd32768, 32'hFFFF8000, 1);
      wait_idle();
      csr_write(REG_GRAV, 31'd0);
      csr_write(REG_STEPS, 31'd0);
      send_body(31'd65536, 32'h12345678, 32'h87654321, 32'h00010000, 32'hFFFF0000, 0);
      send_body(31'd131072, 32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF, 32'h80000000, 1);
      wait_idle();
      csr_write(REG_GRAV, 31'h7FFFFFFF);
      csr_write(REG_STEPS, 31'd3);
      send_body(31'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 0);
      send_body(31'd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 0);
      send_body(31'd65536, 32'd0, 32'd65536, 32'd0, 32'd0, 1);
      wait_idle();
      csr_write(REG_STEPS, 31'hFFFF);
      send_body(31'd65536, 32'd0, 32'd0, 32'h00010000, 32'hFFFF0000, 1);
      wait_idle();
      // Capacity overrun: one body too many, the extra one marked last.
      csr_write(REG_STEPS, 31'd0);
      csr_write(REG_GRAV, 31'd65536);
      steady = 1;
      for (int k = 0; k <= BODY_CAP; k++)
         send_body(rand_mass(), rand_coord(), rand_coord(), $urandom(), $urandom(),
                   k == BODY_CAP);
      steady = 0;
      wait_idle();

      // Random sets; most are small so that the pairwise loops stay short.
      n = bodies_sent + 40;
      while (bodies_sent < n) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            csr_write(REG_GRAV, rand_grav());
            csr_write(REG_STEPS, 31'($urandom_range(0, 3)));
         end
         steady = ($urandom_range(0, 3) == 0);
         cx = rand_coord();
         cy = rand_coord();
         begin
            int set_size;
            set_size = ($urandom_range(0, 9) == 0 && tracker.steps <= 1) ?
                       $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int k = 0; k < set_size; k++) begin
               if ($urandom_range(0, 4) == 0)
                  send_body(rand_mass(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), k == set_size - 1);
               else
                  send_body(rand_mass(), cx + $urandom_range(0, 32'h40000) - 32'h20000,
                            cy + $urandom_range(0, 32'h40000) - 32'h20000,
                            $urandom_range(0, 32'h20000) - 32'h10000,
                            $urandom_range(0, 32'h20000) - 32'h10000, k == set_size - 1);
            end
         end
      end

      wait_idle();
      repeat (50) @(posedge clock);
      $display("Loaded %0d bodies in %0d runs (%0d with dropped bodies).",
               bodies_sent, tracker.runs, tracker.overflow_runs);
      $display("Checked %0d reported bodies, %0d mismatches.",
               tracker.bodies_checked, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// File: nbody_gravity_euler_2d_top.f
src/nbg_pkg.sv
src/nbg_ram.sv
src/nbg_serial.sv
src/nbody_gravity_euler_2d_top.sv
sim/tb.sv
